[rtl/core/odr_pkg.sv]
// Shared types, constants and lookup functions for the 4x4 ordered RGB dither.
// No dependencies; used by odr_pos, odr_lane and ordered_dither_rgb_4x4.
package odr_pkg;

    // Widths fixed by the pixel format and the register map
    localparam int unsigned ChanW   = 8;
    localparam int unsigned LevelW  = 4;
    localparam int unsigned ShiftW  = 3;
    localparam int unsigned ModeW   = 2;
    localparam int unsigned WidthW  = 13;
    localparam int unsigned NumLane = 3;

    // Scale applied to each channel before the threshold is added
    localparam logic [ChanW-1:0] ChanScale = 8'd241;

    // Register indexes on the configuration port
    typedef enum logic [0:0] {
        REG_DEPTH_MODE  = 1'b0,
        REG_IMAGE_WIDTH = 1'b1
    } reg_index_t;

    // Depth mode codes
    typedef enum logic [ModeW-1:0] {
        MODE_444   = 2'd0,
        MODE_323   = 2'd1,
        MODE_233   = 2'd2,
        MODE_SPARE = 2'd3
    } depth_mode_t;

    // Per-lane shift amounts for the current mode
    typedef struct packed {
        logic [ShiftW-1:0] red;
        logic [ShiftW-1:0] green;
        logic [ShiftW-1:0] blue;
    } shift_set_t;

    // One pixel of three channels
    typedef struct packed {
        logic [ChanW-1:0] red;
        logic [ChanW-1:0] green;
        logic [ChanW-1:0] blue;
    } pixel_t;

    // 4x4 Bayer threshold matrix
    function automatic logic [LevelW-1:0] bayer_level(input logic [1:0] row,
                                                      input logic [1:0] col);
        logic [LevelW-1:0] lvl;
        unique case ({row, col})
            4'b00_00: lvl = 4'd0;
            4'b00_01: lvl = 4'd8;
            4'b00_10: lvl = 4'd2;
            4'b00_11: lvl = 4'd10;
            4'b01_00: lvl = 4'd12;
            4'b01_01: lvl = 4'd4;
            4'b01_10: lvl = 4'd14;
            4'b01_11: lvl = 4'd6;
            4'b10_00: lvl = 4'd3;
            4'b10_01: lvl = 4'd11;
            4'b10_10: lvl = 4'd1;
            4'b10_11: lvl = 4'd9;
            4'b11_00: lvl = 4'd15;
            4'b11_01: lvl = 4'd7;
            4'b11_10: lvl = 4'd13;
            default:  lvl = 4'd5;
        endcase
        return lvl;
    endfunction

    // Decode the depth mode into per-channel shifts; the spare code acts as 4,4,4
    function automatic shift_set_t mode_shifts(input depth_mode_t mode);
        shift_set_t s;
        unique case (mode)
            MODE_323: s = '{red: 3'd3, green: 3'd2, blue: 3'd3};
            MODE_233: s = '{red: 3'd2, green: 3'd3, blue: 3'd3};
            MODE_444,
            MODE_SPARE: s = '{red: 3'd4, green: 3'd4, blue: 3'd4};
            default: s = '{red: 3'd4, green: 3'd4, blue: 3'd4};
        endcase
        return s;
    endfunction

endpackage

[rtl/core/odr_pos.sv]
// Raster position tracker: column counter and row phase, giving the Bayer level.
// Depends on odr_pkg.
module odr_pos #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          start_of_frame,
    input  logic [odr_pkg::WidthW-1:0]    image_width,
    output logic [odr_pkg::LevelW-1:0]    level
);

    localparam int unsigned CW = $clog2(MAX_WIDTH);
    localparam int unsigned EW = (CW + 1 > odr_pkg::WidthW) ? CW + 1 : odr_pkg::WidthW;

    logic [CW-1:0] col_reg;
    logic [CW-1:0] col_next;
    logic [1:0]    row_reg;
    logic [1:0]    row_next;
    logic [CW-1:0] col_cur;
    logic [1:0]    row_cur;
    logic [EW-1:0] width_ext;
    logic [EW-1:0] eff_width;
    logic [EW-1:0] col_inc;

    // Frame start restarts the position before this beat
    assign col_cur = start_of_frame ? '0 : col_reg;
    assign row_cur = start_of_frame ? 2'd0 : row_reg;

    assign level = odr_pkg::bayer_level(row_cur, col_cur[1:0]);

    // Out-of-range width falls back to the maximum
    assign width_ext = EW'(image_width);
    assign eff_width = ((width_ext == '0) || (width_ext > EW'(MAX_WIDTH)))
                     ? EW'(MAX_WIDTH) : width_ext;
    assign col_inc   = EW'(col_cur) + EW'(1);

    // Wrap the column at the row end and step the row phase
    always_comb
    begin
        if (col_inc >= eff_width)
        begin
            col_next = '0;
            row_next = row_cur + 2'd1;
        end
        else
        begin
            col_next = col_inc[CW-1:0];
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= 2'd0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

[rtl/core/odr_lane.sv]
// One channel lane: scale by 241, add the threshold, clear the low bits.
// Depends on odr_pkg.
module odr_lane (
    input  logic [odr_pkg::ChanW-1:0]  chan,
    input  logic [odr_pkg::LevelW-1:0] level,
    input  logic [odr_pkg::ShiftW-1:0] shift,
    output logic [odr_pkg::ChanW-1:0]  result
);

    logic [2*odr_pkg::ChanW-1:0] prod;
    logic [odr_pkg::ChanW-1:0]   sum;
    logic [odr_pkg::ChanW-1:0]   mask;

    // Scale; the high byte plus the level never exceeds 255
    assign prod = 16'(chan) * 16'(odr_pkg::ChanScale);
    assign sum  = prod[2*odr_pkg::ChanW-1:odr_pkg::ChanW] + 8'(level);

    // Drop the bits below the target depth
    assign mask   = 8'hFF << shift;
    assign result = sum & mask;

endmodule

[rtl/core/ordered_dither_rgb_4x4.sv]
// Top level of the 4x4 ordered RGB dither: config registers, lanes, output skid.
// Depends on odr_pkg, odr_pos and odr_lane.
//
// Usage:
//   Pixels arrive on the pixel channel (pixel_valid / pixel_stall) in raster
//   order; start_of_frame on a beat returns row and column to zero for it.
//   Dithered pixels leave on the result channel (result_valid / result_stall),
//   one result beat for every pixel beat, in order.
//   A taken pixel goes to the result register, or to the skid register under
//   a result stall. Throughput is one pixel per clock while pixel_stall is
//   low, set by three parallel channel lanes on a single registered stage.
//   The result register is backed by a one-beat skid register; pixel_stall
//   rises only when that skid register is occupied, so a stall on the result
//   side reaches the pixel side through the skid and no beat is lost.
//   Configuration (cfg_write, cfg_index, cfg_data) must be written only while
//   the stream is idle; the block does not enforce it. Index 0 is depth_mode,
//   index 1 is image_width. Reset clears the position to row 0 column 0,
//   empties both output registers, sets depth_mode to 0, image_width to 640.
module ordered_dither_rgb_4x4 #(
    parameter int unsigned MAX_WIDTH = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_write,
    input  logic [0:0]                    cfg_index,
    input  logic [odr_pkg::WidthW-1:0]    cfg_data,
    // pixel channel
    input  logic                          pixel_valid,
    output logic                          pixel_stall,
    input  logic                          start_of_frame,
    input  logic [odr_pkg::ChanW-1:0]     red_in,
    input  logic [odr_pkg::ChanW-1:0]     green_in,
    input  logic [odr_pkg::ChanW-1:0]     blue_in,
    // result channel
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [odr_pkg::ChanW-1:0]     red_out,
    output logic [odr_pkg::ChanW-1:0]     green_out,
    output logic [odr_pkg::ChanW-1:0]     blue_out
);

    odr_pkg::depth_mode_t        mode_reg;
    logic [odr_pkg::WidthW-1:0]  width_reg;
    odr_pkg::shift_set_t         shifts;
    logic [odr_pkg::LevelW-1:0]  level;
    odr_pkg::pixel_t             dith;
    odr_pkg::pixel_t             out_reg;
    odr_pkg::pixel_t             skid_reg;
    logic                        out_valid_reg;
    logic                        skid_valid_reg;
    logic                        accept;
    logic                        out_free;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= odr_pkg::MODE_444;
            width_reg <= 13'd640;
        end
        else if (cfg_write)
        begin
            unique case (odr_pkg::reg_index_t'(cfg_index))
                odr_pkg::REG_DEPTH_MODE:
                    mode_reg <= odr_pkg::depth_mode_t'(cfg_data[odr_pkg::ModeW-1:0]);
                odr_pkg::REG_IMAGE_WIDTH:
                    width_reg <= cfg_data;
                default:
                    width_reg <= width_reg;
            endcase
        end
    end

    assign shifts = odr_pkg::mode_shifts(mode_reg);

    assign accept   = pixel_valid && !skid_valid_reg;
    assign out_free = !out_valid_reg || !result_stall;

    // Position tracking
    odr_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (accept),
        .start_of_frame (start_of_frame),
        .image_width    (width_reg),
        .level          (level)
    );

    // Three channel lanes side by side
    odr_lane u_lane_red (
        .chan   (red_in),
        .level  (level),
        .shift  (shifts.red),
        .result (dith.red)
    );

    odr_lane u_lane_green (
        .chan   (green_in),
        .level  (level),
        .shift  (shifts.green),
        .result (dith.green)
    );

    odr_lane u_lane_blue (
        .chan   (blue_in),
        .level  (level),
        .shift  (shifts.blue),
        .result (dith.blue)
    );

    // Merge the lanes into the result beat; hold in the skid when stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_reg <= skid_valid_reg ? skid_reg : dith;
        end
        else if (accept)
        begin
            skid_reg <= dith;
        end
    end

    assign pixel_stall  = skid_valid_reg;
    assign result_valid = out_valid_reg;
    assign red_out      = out_reg.red;
    assign green_out    = out_reg.green;
    assign blue_out     = out_reg.blue;

    // The skid only fills behind an occupied result register
    assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid occupied while result register empty");

    // A beat taken against a stalled result lands in the skid
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && out_valid_reg && result_stall) |=> skid_valid_reg)
        else $error("beat taken under stall was not kept");

    // A held skid beat keeps its value until it moves up
    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && result_stall) |=> (skid_valid_reg && $stable(skid_reg)))
        else $error("skid beat changed or lost while stalled");

    // A freed result register takes the skid beat next
    assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !result_stall) |=> (out_valid_reg && !skid_valid_reg
                                              && out_reg == $past(skid_reg)))
        else $error("skid beat not moved to the result register");

endmodule
